@@ rtl/core/xml_entity_escaper_assert.svh @@
// Assertion macros for the XML entity escaper.
// Each check is sampled on the rising clock edge and is off while reset is active.
`ifndef XML_ENTITY_ESCAPER_ASSERT_SVH
`define XML_ENTITY_ESCAPER_ASSERT_SVH

`ifndef SYNTHESIS
`define XEE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define XEE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define XEE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define XEE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/core/xee_pkg.sv @@
`default_nettype none

package xee_pkg;

  typedef enum logic [2:0] {
    ESC_PASS,
    ESC_LT,
    ESC_GT,
    ESC_AMP,
    ESC_QUOT,
    ESC_APOS,
    ESC_CREF
  } esc_kind_t;

  // one classified input byte, as it waits between front and back
  typedef struct packed {
    esc_kind_t  kind;
    logic [7:0] ch;
    logic [2:0] len;
    logic       text_end;
  } esc_item_t;

  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_SPC  = 8'h20;

  localparam logic [2:0] LEN_ONE  = 3'd1;
  localparam logic [2:0] LEN_FOUR = 3'd4;
  localparam logic [2:0] LEN_FIVE = 3'd5;
  localparam logic [2:0] LEN_SIX  = 3'd6;

endpackage

`default_nettype wire

@@ rtl/core/xml_entity_escaper.sv @@
// Bytes are registered in the item queue, then in the output register.
// Output: one byte per cycle while items are queued, 1 to 6 per input byte.
// Throughput: one item per cycle for pass-through bytes; escaped bytes hold
// the emitter for 4 to 6 entity bytes; busy rises once the item queue fills.
// Reset (rst_n low, synchronous) empties the queue and drops out_valid.
// The receiver cannot stall; every out_valid cycle is one transfer.
`default_nettype none

module xml_entity_escaper #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       in_attribute_mode,
  input  wire logic       in_text_end,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic            out_item_last,
  output logic            out_string_last
);
  import xee_pkg::*;

  esc_item_t push_item;
  esc_item_t head;
  logic      push, pop, empty, full;

  xee_front u_front (
    .start             (start),
    .in_char_byte      (in_char_byte),
    .in_attribute_mode (in_attribute_mode),
    .in_text_end       (in_text_end),
    .full_i            (full),
    .busy              (busy),
    .push_o            (push),
    .item_o            (push_item)
  );

  xee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  xee_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_i          (head),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_item_last   (out_item_last),
    .out_string_last (out_string_last)
  );

endmodule

`default_nettype wire

@@ rtl/core/xee_front.sv @@
`default_nettype none

module xee_front (
  input  wire logic              start,
  input  wire logic [7:0]        in_char_byte,
  input  wire logic              in_attribute_mode,
  input  wire logic              in_text_end,
  input  wire logic              full_i,
  output logic                   busy,
  output logic                   push_o,
  output xee_pkg::esc_item_t     item_o
);
  import xee_pkg::*;

  always_comb begin
    item_o.ch       = in_char_byte;
    item_o.text_end = in_text_end;
    item_o.kind     = ESC_PASS;
    item_o.len      = LEN_ONE;
    if (in_char_byte == CH_LT) begin
      item_o.kind = ESC_LT;
      item_o.len  = LEN_FOUR;
    end else if (in_char_byte == CH_GT) begin
      item_o.kind = ESC_GT;
      item_o.len  = LEN_FOUR;
    end else if (in_char_byte == CH_AMP) begin
      item_o.kind = ESC_AMP;
      item_o.len  = LEN_FIVE;
    end else if (in_attribute_mode && in_char_byte == CH_DQ) begin
      item_o.kind = ESC_QUOT;
      item_o.len  = LEN_SIX;
    end else if (in_attribute_mode && in_char_byte == CH_APOS) begin
      item_o.kind = ESC_APOS;
      item_o.len  = LEN_SIX;
    end else if (in_char_byte < CH_SPC && in_char_byte != CH_TAB &&
                 in_char_byte != CH_LF) begin
      // &#xN; or &#x1N;
      item_o.kind = ESC_CREF;
      item_o.len  = in_char_byte[4] ? LEN_SIX : LEN_FIVE;
    end
  end

  assign busy   = full_i;
  assign push_o = start && !full_i;

endmodule

`default_nettype wire

@@ rtl/core/xee_queue.sv @@
`default_nettype none

module xee_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_i,
  input  wire xee_pkg::esc_item_t item_i,
  input  wire logic               pop_i,
  output xee_pkg::esc_item_t      head_o,
  output logic                    empty_o,
  output logic                    full_o
);
  import xee_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  esc_item_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full_o  = (cnt_r == CW'(DEPTH));
  assign empty_o = (cnt_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/xee_back.sv @@
`default_nettype none
`include "xml_entity_escaper_assert.svh"

module xee_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire xee_pkg::esc_item_t head_i,
  input  wire logic               empty_i,
  output logic                    pop_o,
  output logic                    out_valid,
  output logic [7:0]              out_byte,
  output logic                    out_item_last,
  output logic                    out_string_last
);
  import xee_pkg::*;

  localparam logic [47:0] ENT_LT   = {"&lt;", 16'h0000};
  localparam logic [47:0] ENT_GT   = {"&gt;", 16'h0000};
  localparam logic [47:0] ENT_AMP  = {"&amp;", 8'h00};
  localparam logic [47:0] ENT_QUOT = "&quot;";
  localparam logic [47:0] ENT_APOS = "&apos;";
  localparam logic [47:0] ENT_CREF = {"&#x", 24'h000000};

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       ilast_r, ilast_nxt;
  logic       slast_r, slast_nxt;
  logic       is_last;

  function automatic logic [7:0] pick6(input logic [47:0] s, input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = s[47:40];
      3'd1:    b = s[39:32];
      3'd2:    b = s[31:24];
      3'd3:    b = s[23:16];
      3'd4:    b = s[15:8];
      3'd5:    b = s[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] b;
    b = (nib < 4'd10) ? 8'h30 + {4'h0, nib} : 8'h37 + {4'h0, nib};
    return b;
  endfunction

  function automatic logic [7:0] esc_byte(input esc_item_t it, input logic [2:0] i);
    logic [7:0] b;
    logic [2:0] tail;
    b    = 8'h00;
    tail = it.ch[4] ? i - 3'd1 : i;
    case (it.kind)
      ESC_PASS: b = it.ch;
      ESC_LT:   b = pick6(ENT_LT, i);
      ESC_GT:   b = pick6(ENT_GT, i);
      ESC_AMP:  b = pick6(ENT_AMP, i);
      ESC_QUOT: b = pick6(ENT_QUOT, i);
      ESC_APOS: b = pick6(ENT_APOS, i);
      ESC_CREF: begin
        // prefix, optional '1' for 0x10-0x1F, digit, ';'
        if (i < 3'd3) begin
          b = pick6(ENT_CREF, i);
        end else if (it.ch[4] && i == 3'd3) begin
          b = "1";
        end else if (tail == 3'd3) begin
          b = hex_digit(it.ch[3:0]);
        end else begin
          b = ";";
        end
      end
      default:  b = it.ch;
    endcase
    return b;
  endfunction

  assign is_last = (idx_r == head_i.len - 3'd1);
  assign pop_o   = !empty_i && is_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = !empty_i;
    byte_nxt  = esc_byte(head_i, idx_r);
    ilast_nxt = is_last;
    slast_nxt = is_last && head_i.text_end;
    if (!empty_i) begin
      idx_nxt = is_last ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    ilast_r <= ilast_nxt;
    slast_r <= slast_nxt;
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_item_last   = valid_r && ilast_r;
  assign out_string_last = valid_r && slast_r;

  `XEE_ASSERT_SAME(a_idx_in_range, clk, rst_n, !empty_i, idx_r < head_i.len, "index past entity")
  `XEE_ASSERT_NEXT(a_head_emits, clk, rst_n, !empty_i, out_valid, "queued item not emitted")
  `XEE_ASSERT_NEXT(a_no_gap, clk, rst_n, out_valid && !out_item_last, out_valid, "gap in sequence")
  `XEE_ASSERT_SAME(a_slast_ilast, clk, rst_n, out_string_last, out_item_last, "string end early")

endmodule

`default_nettype wire
